### design/bootloader_frame_sender_core_assert.svh
`ifndef BOOTLOADER_FRAME_SENDER_CORE_ASSERT_SVH
`define BOOTLOADER_FRAME_SENDER_CORE_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define BFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define BFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/bfs_pkg.sv
package bfs_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] status;
    logic       run_end;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FW    = 2'd1,
    OP_RX    = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_READY     = 4'd1,
    ST_ACKED     = 4'd2,
    ST_RETRY     = 4'd3,
    ST_HS_FAIL   = 4'd4,
    ST_ABORTED   = 4'd5,
    ST_DONE_OK   = 4'd6,
    ST_DONE_NOCF = 4'd7,
    ST_IGNORED   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HS_WAIT, PH_GATHER, PH_ACK_WAIT, PH_GAP, PH_EOF_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_HDR, SQ_DATA, SQ_CRC_HI, SQ_CRC_LO, SQ_EOF
  } seq_t;

  localparam logic [2:0] REG_START_ADDR = 3'd0;
  localparam logic [2:0] REG_ACK_TMO    = 3'd1;
  localparam logic [2:0] REG_READY_TMO  = 3'd2;
  localparam logic [2:0] REG_HS_TRIES   = 3'd3;
  localparam logic [2:0] REG_MAX_RETRY  = 3'd4;
  localparam logic [2:0] REG_GAP        = 3'd5;
  localparam logic [2:0] REG_EOF_TMO    = 3'd6;

  localparam logic [23:0] START_ADDR_RST = 24'h008400;
  localparam logic [7:0]  BYTE_TRIGGER   = 8'h7F;
  localparam logic [7:0]  TGT_OK_BYTE    = 8'h79;
  localparam logic [7:0]  END_MARK_BYTE  = 8'hFF;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic out_item_t mk_res(input logic v, input logic [7:0] b,
                                       input status_t st, input logic e);
    out_item_t r;
    r.tx_valid = v;
    r.tx_byte  = v ? b : 8'h00;
    r.status   = st;
    r.run_end  = e;
    return r;
  endfunction

endpackage

### design/bootloader_frame_sender_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | bfs_pkg::in_item_t (operation, byte, last)
// out_    | output    | out_valid/out_ready| bfs_pkg::out_item_t (tx byte, status, run end)
// cfg_    | input     | cfg_we             | cfg_index selects register, cfg_wdata 24 bit
//
// The ack of the final frame also sends the end marker. An item that sends a
// frame is accepted, then four header bytes, fill data bytes and two CRC bytes
// go out one byte per cycle while the output is not stalled, through the CRC
// unit, the data bytes from the chunk store. Output stalls hold the sequencer.
// Output stalls add cycles one for one. Reset is synchronous, active low.
module bootloader_frame_sender_core #(
  parameter int CHUNK_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfs_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import bfs_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_BYTES + 1);
  localparam int IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  // configuration
  logic [23:0] start_addr_r;
  logic [15:0] ack_tmo_r, ready_tmo_r, gap_r, eof_tmo_r;
  logic [3:0]  hs_tries_r, max_retry_r;

  // protocol state
  phase_t            phase_r, phase_nxt;
  seq_t              seq_r, seq_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [23:0]       ptr_r, ptr_nxt;
  logic [3:0]        att_r, att_nxt;
  logic [15:0]       timer_r, timer_nxt;
  logic              final_r, final_nxt;

  // frame sequencer datapath
  logic [15:0]       crc_r, crc_nxt;
  logic [1:0]        hdr_idx_r, hdr_idx_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [7:0] store_r [CHUNK_BYTES];
  logic       store_we;

  logic              out_free;
  logic [15:0]       tmr_inc;
  logic [FILL_W-1:0] fill_inc, idx_inc;
  logic [7:0]        hdr_byte, data_byte_rd, emit_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (seq_r == SQ_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign tmr_inc  = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
  assign fill_inc = fill_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;

  always_comb begin
    unique case (hdr_idx_r)
      2'd0:    hdr_byte = ptr_r[23:16];
      2'd1:    hdr_byte = ptr_r[15:8];
      2'd2:    hdr_byte = ptr_r[7:0];
      default: hdr_byte = 8'(fill_r);
    endcase
  end

  assign data_byte_rd = store_r[idx_r[IDX_W-1:0]];
  // the CRC unit sees whichever frame byte goes out this cycle
  assign emit_byte    = (seq_r == SQ_HDR) ? hdr_byte : data_byte_rd;

  always_comb begin
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    att_nxt       = att_r;
    timer_nxt     = timer_r;
    final_nxt     = final_r;
    crc_nxt       = crc_r;
    hdr_idx_nxt   = hdr_idx_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    store_we      = 1'b0;

    unique case (seq_r)
      SQ_IDLE: begin
        if (in_valid && out_free) begin
          unique case (op_t'(in_data.operation))
            OP_START: begin
              if (phase_r == PH_IDLE) begin
                fill_nxt  = '0;
                ptr_nxt   = start_addr_r;
                final_nxt = 1'b0;
                att_nxt   = 4'd1;
                timer_nxt = '0;
                phase_nxt = PH_HS_WAIT;
                out_nxt = mk_res(1'b1, BYTE_TRIGGER, ST_NONE, 1'b1);
                out_valid_nxt = 1'b1;
              end else begin
                out_nxt = mk_res(1'b0, 8'h00, ST_IGNORED, 1'b1);
                out_valid_nxt = 1'b1;
              end
            end
            OP_FW: begin
              if (phase_r == PH_GATHER && fill_r < FILL_W'(CHUNK_BYTES)) begin
                store_we = 1'b1;
                fill_nxt = fill_inc;
                if (fill_inc >= FILL_W'(CHUNK_BYTES) || in_data.last_byte) begin
                  final_nxt   = in_data.last_byte;
                  att_nxt     = 4'd1;
                  phase_nxt   = PH_ACK_WAIT;
                  timer_nxt   = '0;
                  seq_nxt     = SQ_HDR;
                  hdr_idx_nxt = '0;
                  crc_nxt     = CRC_INIT;
                end
              end else begin
                out_nxt = mk_res(1'b0, 8'h00, ST_IGNORED, 1'b1);
                out_valid_nxt = 1'b1;
              end
            end
            OP_RX: begin
              out_valid_nxt = 1'b1;
              priority case (phase_r)
                PH_HS_WAIT: begin
                  if (in_data.data_byte == TGT_OK_BYTE) begin
                    phase_nxt = PH_GATHER;
                    fill_nxt  = '0;
                    out_nxt = mk_res(1'b0, 8'h00, ST_READY, 1'b1);
                  end else if (att_r >= hs_tries_r) begin
                    out_nxt = mk_res(1'b0, 8'h00, ST_HS_FAIL, 1'b1);
                    phase_nxt = PH_IDLE;
                  end else begin
                    att_nxt   = att_r + 4'd1;
                    timer_nxt = '0;
                    out_nxt = mk_res(1'b1, BYTE_TRIGGER, ST_NONE, 1'b1);
                  end
                end
                PH_ACK_WAIT: begin
                  if (in_data.data_byte == TGT_OK_BYTE) begin
                    ptr_nxt  = ptr_r + 24'(fill_r);
                    fill_nxt = '0;
                    out_nxt = mk_res(1'b0, 8'h00, ST_ACKED, !final_r);
                    if (final_r) begin
                      phase_nxt = PH_EOF_WAIT;
                      timer_nxt = '0;
                      seq_nxt   = SQ_EOF;
                    end else begin
                      phase_nxt = PH_GATHER;
                    end
                  end else if (att_r >= max_retry_r) begin
                    out_nxt = mk_res(1'b0, 8'h00, ST_ABORTED, 1'b1);
                    phase_nxt = PH_IDLE;
                  end else begin
                    out_nxt = mk_res(1'b0, 8'h00, ST_RETRY, 1'b1);
                    phase_nxt = PH_GAP;
                    timer_nxt = '0;
                  end
                end
                PH_EOF_WAIT: begin
                  out_nxt = mk_res(1'b0, 8'h00,
                    (in_data.data_byte == TGT_OK_BYTE) ? ST_DONE_OK : ST_DONE_NOCF, 1'b1);
                  phase_nxt = PH_IDLE;
                end
                default: begin
                  out_nxt = mk_res(1'b0, 8'h00, ST_IGNORED, 1'b1);
                end
              endcase
            end
            default: begin
              // tick: advance the wait timer of the waiting phase
              priority case (phase_r)
                PH_HS_WAIT: begin
                  timer_nxt = tmr_inc;
                  if (tmr_inc >= ready_tmo_r) begin
                    out_valid_nxt = 1'b1;
                    if (att_r >= hs_tries_r) begin
                      out_nxt = mk_res(1'b0, 8'h00, ST_HS_FAIL, 1'b1);
                      phase_nxt = PH_IDLE;
                    end else begin
                      att_nxt   = att_r + 4'd1;
                      timer_nxt = '0;
                      out_nxt = mk_res(1'b1, BYTE_TRIGGER, ST_NONE, 1'b1);
                    end
                  end
                end
                PH_ACK_WAIT: begin
                  timer_nxt = tmr_inc;
                  if (tmr_inc >= ack_tmo_r) begin
                    out_valid_nxt = 1'b1;
                    if (att_r >= max_retry_r) begin
                      out_nxt = mk_res(1'b0, 8'h00, ST_ABORTED, 1'b1);
                      phase_nxt = PH_IDLE;
                    end else begin
                      out_nxt = mk_res(1'b0, 8'h00, ST_RETRY, 1'b1);
                      phase_nxt = PH_GAP;
                      timer_nxt = '0;
                    end
                  end
                end
                PH_GAP: begin
                  timer_nxt = tmr_inc;
                  if (tmr_inc >= gap_r) begin
                    att_nxt     = att_r + 4'd1;
                    phase_nxt   = PH_ACK_WAIT;
                    timer_nxt   = '0;
                    seq_nxt     = SQ_HDR;
                    hdr_idx_nxt = '0;
                    crc_nxt     = CRC_INIT;
                  end
                end
                PH_EOF_WAIT: begin
                  timer_nxt = tmr_inc;
                  if (tmr_inc >= eof_tmo_r) begin
                    out_valid_nxt = 1'b1;
                    out_nxt = mk_res(1'b0, 8'h00, ST_DONE_NOCF, 1'b1);
                    phase_nxt = PH_IDLE;
                  end
                end
                default: ;
              endcase
            end
          endcase
        end
      end
      SQ_HDR, SQ_DATA: begin
        if (out_free) begin
          out_nxt = mk_res(1'b1, emit_byte, ST_NONE, 1'b0);
          out_valid_nxt = 1'b1;
          crc_nxt = crc_byte(crc_r, emit_byte);
          if (seq_r == SQ_HDR) begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
            if (hdr_idx_r == 2'd3) begin
              seq_nxt = SQ_DATA;
              idx_nxt = '0;
            end
          end else begin
            idx_nxt = idx_inc;
            if (idx_inc == fill_r) seq_nxt = SQ_CRC_HI;
          end
        end
      end
      SQ_CRC_HI: begin
        if (out_free) begin
          out_nxt = mk_res(1'b1, crc_r[15:8], ST_NONE, 1'b0);
          out_valid_nxt = 1'b1;
          seq_nxt = SQ_CRC_LO;
        end
      end
      SQ_CRC_LO: begin
        if (out_free) begin
          out_nxt = mk_res(1'b1, crc_r[7:0], ST_NONE, 1'b1);
          out_valid_nxt = 1'b1;
          seq_nxt = SQ_IDLE;
        end
      end
      default: begin
        // end marker after the final frame ack
        if (out_free) begin
          out_nxt = mk_res(1'b1, END_MARK_BYTE, ST_NONE, 1'b1);
          out_valid_nxt = 1'b1;
          seq_nxt = SQ_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= START_ADDR_RST;
      ack_tmo_r    <= 16'd1500;
      ready_tmo_r  <= 16'd400;
      hs_tries_r   <= 4'd8;
      max_retry_r  <= 4'd3;
      gap_r        <= 16'd80;
      eof_tmo_r    <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_ADDR: start_addr_r <= cfg_wdata;
        REG_ACK_TMO:    ack_tmo_r    <= cfg_wdata[15:0];
        REG_READY_TMO:  ready_tmo_r  <= cfg_wdata[15:0];
        REG_HS_TRIES:   hs_tries_r   <= cfg_wdata[3:0];
        REG_MAX_RETRY:  max_retry_r  <= cfg_wdata[3:0];
        REG_GAP:        gap_r        <= cfg_wdata[15:0];
        REG_EOF_TMO:    eof_tmo_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_r       <= SQ_IDLE;
      fill_r      <= '0;
      ptr_r       <= START_ADDR_RST;
      att_r       <= '0;
      timer_r     <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      att_r       <= att_nxt;
      timer_r     <= timer_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    crc_r     <= crc_nxt;
    hdr_idx_r <= hdr_idx_nxt;
    idx_r     <= idx_nxt;
    out_r     <= out_nxt;
    if (store_we) store_r[fill_r[IDX_W-1:0]] <= in_data.data_byte;
  end

`include "bootloader_frame_sender_core_assert.svh"
  `BFS_ASSERT_IMPL(a_ready_only_idle, in_ready, seq_r == SQ_IDLE)
  `BFS_ASSERT_IMPL(a_data_nonempty, seq_r == SQ_DATA, fill_r != '0)
  `BFS_ASSERT_IMPL(a_frame_in_ack, seq_r == SQ_CRC_LO, phase_r == PH_ACK_WAIT)
  `BFS_ASSERT_IMPL(a_eof_phase, seq_r == SQ_EOF, phase_r == PH_EOF_WAIT)
  `BFS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FILL_W'(CHUNK_BYTES))
  `BFS_ASSERT_NEXT(a_crc_follows, seq_r == SQ_CRC_HI && out_free, seq_r == SQ_CRC_LO)

endmodule
